@@ rtl/sqe_pkg.sv @@
package sqe_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int WORD_BITS_DEF = 32;

	localparam int DATA_W = 32;
	localparam int MODE_W = 3;
	localparam int STATUS_W = 2;

	localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
	localparam logic [MODE_W-1:0] MODE_POP  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PEEK = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SWAP = 3'd3;
	localparam logic [MODE_W-1:0] MODE_LIST = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic                push_en;
		logic                pop_en;
		logic                rd_top;
		logic                rd_second;
		logic                rd_cursor;
		logic                list_init;
		logic                hold_ld;
		logic                wr_top_rd;
		logic                wr_second_hold;
		logic                out_ld;
		logic                out_sel_data;
		logic [STATUS_W-1:0] out_status;
		logic                out_last;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic short_cnt;
		logic list_last;
	} stat_t;

endpackage

@@ rtl/sqe_if.sv @@
interface sqe_req_if;
	import sqe_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [MODE_W-1:0]        mode;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink (input valid, input mode, input value, output ready);
endinterface

interface sqe_rsp_if;
	import sqe_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] data;
	logic [STATUS_W-1:0]      status;
	logic                     last;

	modport source (output valid, output data, output status, output last, input ready);
	modport sink (input valid, input data, input status, input last, output ready);
endinterface

@@ rtl/sqe_datapath.sv @@
module sqe_datapath #(
	parameter int DEPTH = sqe_pkg::DEPTH_DEF,
	parameter int WORD_BITS = sqe_pkg::WORD_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_wr_en,
	input  logic                                     cfg_wr_data,
	input  logic signed [sqe_pkg::DATA_W-1:0]        value,
	input  sqe_pkg::cmd_t                            cmd,
	output sqe_pkg::stat_t                           stat,
	output logic signed [sqe_pkg::DATA_W-1:0]        data,
	output logic [sqe_pkg::STATUS_W-1:0]             status,
	output logic                                     last
);
	import sqe_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	logic [WORD_BITS-1:0] mem_q [DEPTH];
	logic [WORD_BITS-1:0] rd_q;
	logic [WORD_BITS-1:0] hold_q;
	logic [PTR_W-1:0]     top_q;
	logic [CNT_W-1:0]     count_q;
	logic [PTR_W-1:0]     cursor_q;
	logic [CNT_W-1:0]     remain_q;
	logic                 queue_mode_q;

	logic signed [DATA_W-1:0] data_q;
	logic [STATUS_W-1:0]      status_q;
	logic                     last_q;

	logic [PTR_W-1:0]     top_next;
	logic [PTR_W-1:0]     top_prev;
	logic [PTR_W-1:0]     cursor_next;
	logic [SUM_W-1:0]     tail_sum;
	logic [SUM_W-1:0]     tail_wrap;
	logic [PTR_W-1:0]     push_addr;
	logic [WORD_BITS-1:0] push_word;
	logic [DATA_W-1:0]    word_data;
	logic                 wr_en;
	logic [PTR_W-1:0]     wr_addr;
	logic [WORD_BITS-1:0] wr_word;
	logic                 rd_en;
	logic [PTR_W-1:0]     rd_addr;

	generate
		if (WORD_BITS >= DATA_W) begin : g_wide
			assign word_data = rd_q[DATA_W-1:0];
		end else begin : g_narrow
			assign word_data = {{(DATA_W - WORD_BITS){rd_q[WORD_BITS-1]}}, rd_q};
		end
		if (WORD_BITS <= DATA_W) begin : g_store_narrow
			assign push_word = value[WORD_BITS-1:0];
		end else begin : g_store_wide
			assign push_word = {{(WORD_BITS - DATA_W){1'b0}}, value};
		end
	endgenerate

	assign top_next    = (top_q == PTR_W'(DEPTH - 1)) ? '0 : top_q + 1'b1;
	assign top_prev    = (top_q == '0) ? PTR_W'(DEPTH - 1) : top_q - 1'b1;
	assign cursor_next = (cursor_q == PTR_W'(DEPTH - 1)) ? '0 : cursor_q + 1'b1;
	assign tail_sum    = SUM_W'(top_q) + SUM_W'(count_q);
	assign tail_wrap   = (tail_sum >= SUM_W'(DEPTH)) ? tail_sum - SUM_W'(DEPTH) : tail_sum;

	always_comb begin
		if (count_q == '0) begin
			push_addr = top_q;
		end else if (!queue_mode_q) begin
			push_addr = top_prev;
		end else begin
			push_addr = tail_wrap[PTR_W-1:0];
		end
	end

	always_comb begin
		wr_en   = cmd.push_en || cmd.wr_top_rd || cmd.wr_second_hold;
		wr_addr = push_addr;
		wr_word = push_word;
		if (cmd.wr_top_rd) begin
			wr_addr = top_q;
			wr_word = rd_q;
		end else if (cmd.wr_second_hold) begin
			wr_addr = top_next;
			wr_word = hold_q;
		end
	end

	always_comb begin
		rd_en   = cmd.rd_top || cmd.rd_second || cmd.rd_cursor;
		rd_addr = top_q;
		if (cmd.rd_second) begin
			rd_addr = top_next;
		end else if (cmd.rd_cursor) begin
			rd_addr = cursor_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_word;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hold_ld) begin
			hold_q <= rd_q;
		end
		if (cmd.out_ld) begin
			data_q   <= cmd.out_sel_data ? word_data : '0;
			status_q <= cmd.out_status;
			last_q   <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q        <= '0;
			count_q      <= '0;
			cursor_q     <= '0;
			remain_q     <= '0;
			queue_mode_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				queue_mode_q <= cfg_wr_data;
			end
			if (cmd.push_en) begin
				if (count_q != '0 && !queue_mode_q) begin
					top_q <= top_prev;
				end
				count_q <= count_q + 1'b1;
			end else if (cmd.pop_en) begin
				top_q   <= top_next;
				count_q <= count_q - 1'b1;
			end
			if (cmd.list_init) begin
				cursor_q <= top_next;
				remain_q <= count_q;
			end else if (cmd.rd_cursor) begin
				cursor_q <= cursor_next;
				remain_q <= remain_q - 1'b1;
			end
		end
	end

	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q == CNT_W'(DEPTH));
	assign stat.short_cnt = (count_q < CNT_W'(2));
	assign stat.list_last = (remain_q == CNT_W'(1));

	assign data   = data_q;
	assign status = status_q;
	assign last   = last_q;

endmodule

@@ rtl/sqe_ctrl.sv @@
module sqe_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic [sqe_pkg::MODE_W-1:0] req_mode,
	input  sqe_pkg::stat_t             stat,
	output sqe_pkg::cmd_t              cmd,
	output logic                       rsp_valid,
	input  logic                       rsp_ready
);
	import sqe_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_PEEK    = 3'd1;
	localparam logic [2:0] S_SWAP_B  = 3'd2;
	localparam logic [2:0] S_SWAP_W1 = 3'd3;
	localparam logic [2:0] S_SWAP_W2 = 3'd4;
	localparam logic [2:0] S_LIST    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE) && slot_free;
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid && slot_free) begin
					cmd.out_last = 1'b1;
					case (req_mode)
						MODE_PUSH: begin
							cmd.out_ld = 1'b1;
							if (stat.full) begin
								cmd.out_status = ST_FULL;
							end else begin
								cmd.push_en    = 1'b1;
								cmd.out_status = ST_OK;
							end
						end
						MODE_POP: begin
							cmd.out_ld = 1'b1;
							if (stat.empty) begin
								cmd.out_status = ST_EMPTY;
							end else begin
								cmd.pop_en     = 1'b1;
								cmd.out_status = ST_OK;
							end
						end
						MODE_PEEK: begin
							if (stat.empty) begin
								cmd.out_ld     = 1'b1;
								cmd.out_status = ST_EMPTY;
							end else begin
								cmd.rd_top = 1'b1;
								state_nxt  = S_PEEK;
							end
						end
						MODE_SWAP: begin
							if (stat.short_cnt) begin
								cmd.out_ld     = 1'b1;
								cmd.out_status = ST_SHORT;
							end else begin
								cmd.rd_top = 1'b1;
								state_nxt  = S_SWAP_B;
							end
						end
						MODE_LIST: begin
							if (stat.empty) begin
								cmd.out_ld     = 1'b1;
								cmd.out_status = ST_EMPTY;
							end else begin
								cmd.rd_top    = 1'b1;
								cmd.list_init = 1'b1;
								state_nxt     = S_LIST;
							end
						end
						default: begin
							cmd.out_ld     = 1'b1;
							cmd.out_status = ST_OK;
						end
					endcase
				end
			end
			S_PEEK: begin
				if (slot_free) begin
					cmd.out_ld       = 1'b1;
					cmd.out_sel_data = 1'b1;
					cmd.out_status   = ST_OK;
					cmd.out_last     = 1'b1;
					state_nxt        = S_IDLE;
				end
			end
			S_SWAP_B: begin
				cmd.hold_ld   = 1'b1;
				cmd.rd_second = 1'b1;
				state_nxt     = S_SWAP_W1;
			end
			S_SWAP_W1: begin
				cmd.wr_top_rd = 1'b1;
				state_nxt     = S_SWAP_W2;
			end
			S_SWAP_W2: begin
				cmd.wr_second_hold = 1'b1;
				if (slot_free) begin
					cmd.out_ld     = 1'b1;
					cmd.out_status = ST_OK;
					cmd.out_last   = 1'b1;
					state_nxt      = S_IDLE;
				end
			end
			S_LIST: begin
				if (slot_free) begin
					cmd.out_ld       = 1'b1;
					cmd.out_sel_data = 1'b1;
					cmd.out_status   = ST_OK;
					cmd.out_last     = stat.list_last;
					if (stat.list_last) begin
						state_nxt = S_IDLE;
					end else begin
						cmd.rd_cursor = 1'b1;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/stack_queue_engine.sv @@
// Channel   Direction  Payload                 Handshake
// req       in         mode, value             valid/ready, taken when both high
// rsp       out        data, status, last      valid/ready, taken when both high
// cfg       in         cfg_wr_data (queue_mode) cfg_wr_en, written at that edge
//
// Push, pop and the unused commands finish at the accepting edge; the result is
// shown in the next cycle. Peek, swap and list first read the top; swap then
// reads the second and writes the two back in turn, as the entry memory has a
// single read and single write port. List gives one entry per cycle while
// results are taken, else the next load waits. Reset clears the pointer,
// count and mode; entry memory is not cleared and is read only where written.
module stack_queue_engine #(
	parameter int DEPTH = sqe_pkg::DEPTH_DEF,
	parameter int WORD_BITS = sqe_pkg::WORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sqe_req_if.sink   req,
	sqe_rsp_if.source rsp,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data
);
	import sqe_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	sqe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_mode  (req.mode),
		.stat      (stat),
		.cmd       (cmd),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready)
	);

	sqe_datapath #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.value       (req.value),
		.cmd         (cmd),
		.stat        (stat),
		.data        (rsp.data),
		.status      (rsp.status),
		.last        (rsp.last)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld && rsp.valid |-> rsp.ready)
		else $error("A pending result was overwritten.");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.mode == MODE_PUSH && stat.full
		|=> rsp.valid && rsp.status == ST_FULL && rsp.last)
		else $error("A push into a full store did not report full.");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !stat.empty && !stat.short_cnt)
		else $error("The entry count flags disagree.");

	a_no_write_on_accept_fail: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_en |-> !stat.full && req.valid && req.ready)
		else $error("A push was carried out without an accepted item.");

endmodule
